// File: rtl/bw_pkg.sv
`timescale 1ns / 1ps

package bw_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int WEIGHT_FRAC_BITS = 24;
    localparam int WEIGHT_WIDTH     = 32;
    localparam int LIMIT_WIDTH      = 32;
    // quotient bits kept by the divider: magnitude of a 32-bit signed weight
    localparam int QUOT_BITS        = WEIGHT_WIDTH + 1;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1);

    typedef struct packed {
        logic valid;
        logic degen;
        logic neg_v;
        logic neg_w;
        logic ovf_v;
        logic ovf_w;
    } bw_side_t;

endpackage

// File: rtl/bw_divider.sv
`timescale 1ns / 1ps

module bw_divider #(
    parameter int GW = 73,
    parameter int XW = 97,
    parameter int QB = bw_pkg::QUOT_BITS
) (
    input  logic          clk,
    input  logic [XW-1:0] dividend,
    input  logic [GW-1:0] divisor,
    output logic [QB-1:0] quotient
);

    // one restoring step per stage, one quotient bit each
    logic [GW-1:0] r_reg  [QB];
    logic [QB-1:0] xl_reg [QB];
    logic [QB-1:0] q_reg  [QB];
    logic [GW-1:0] d_reg  [QB];

    logic [GW-1:0] r_in   [QB];
    logic [QB-1:0] xl_in  [QB];
    logic [QB-1:0] q_in   [QB];
    logic [GW-1:0] d_in   [QB];
    logic [GW-1:0] r_next [QB];
    logic [QB-1:0] q_next [QB];

    always_comb
    begin
        logic [GW:0] t;
        logic        ge;
        for (int k = 0; k < QB; k++)
        begin
            if (k == 0)
            begin
                // high part is below the divisor unless the quotient overflows
                r_in[k]  = GW'(dividend[XW-1:QB]);
                xl_in[k] = dividend[QB-1:0];
                q_in[k]  = '0;
                d_in[k]  = divisor;
            end
            else
            begin
                r_in[k]  = r_reg[k-1];
                xl_in[k] = xl_reg[k-1];
                q_in[k]  = q_reg[k-1];
                d_in[k]  = d_reg[k-1];
            end
            t  = {r_in[k], xl_in[k][QB-1-k]};
            ge = (t >= {1'b0, d_in[k]});
            r_next[k] = ge ? GW'(t - {1'b0, d_in[k]}) : t[GW-1:0];
            q_next[k] = {q_in[k][QB-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QB; k++)
        begin
            r_reg[k]  <= r_next[k];
            xl_reg[k] <= xl_in[k];
            q_reg[k]  <= q_next[k];
            d_reg[k]  <= d_in[k];
        end
    end

    assign quotient = q_reg[QB-1];

endmodule

// File: rtl/barycentric_weights_core.sv
`timescale 1ns / 1ps

// channel   ports                                               timing
// ------    ------------------------------------------------    ---------------------------
// input     start, busy, ax..pz                                 transfer when start & !busy
// config    cfg_wr_en, cfg_wr_data                              write when cfg_wr_en
// result    done, weight_u/v/w, degenerate, saturated           one cycle, marked by done
//
// one item per cycle; busy is always low
// reset clears the valid chain and sets the degenerate limit to 1
// results cannot be held off; done pulses once per accepted item

module barycentric_weights_core #(
    parameter int COORD_WIDTH      = bw_pkg::COORD_WIDTH,
    parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_WIDTH-1:0]              ax,
    input  logic [COORD_WIDTH-1:0]              ay,
    input  logic [COORD_WIDTH-1:0]              az,
    input  logic [COORD_WIDTH-1:0]              bx,
    input  logic [COORD_WIDTH-1:0]              by,
    input  logic [COORD_WIDTH-1:0]              bz,
    input  logic [COORD_WIDTH-1:0]              cx,
    input  logic [COORD_WIDTH-1:0]              cy,
    input  logic [COORD_WIDTH-1:0]              cz,
    input  logic [COORD_WIDTH-1:0]              px,
    input  logic [COORD_WIDTH-1:0]              py,
    input  logic [COORD_WIDTH-1:0]              pz,
    input  logic                                cfg_wr_en,
    input  logic [bw_pkg::LIMIT_WIDTH-1:0]      cfg_wr_data,
    output logic                                done,
    output logic [bw_pkg::WEIGHT_WIDTH-1:0]     weight_u,
    output logic [bw_pkg::WEIGHT_WIDTH-1:0]     weight_v,
    output logic [bw_pkg::WEIGHT_WIDTH-1:0]     weight_w,
    output logic                                degenerate,
    output logic                                saturated
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 2;
    localparam int MW = 2 * DW;
    localparam int GW = MW + 1;
    localparam int XW = GW + WEIGHT_FRAC_BITS;
    localparam int QB = bw_pkg::QUOT_BITS;
    localparam int OW = bw_pkg::WEIGHT_WIDTH;
    localparam int LW = bw_pkg::LIMIT_WIDTH;
    localparam int SW = OW + 2;

    localparam logic [QB-1:0] MAX_POS = QB'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic [QB-1:0] MAX_NEG = QB'(64'd1 << (OW - 1));
    localparam logic signed [OW-1:0] W_MAX = OW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic signed [OW-1:0] W_MIN = OW'(64'd1 << (OW - 1));
    localparam logic signed [SW-1:0] S_MAX = SW'((64'd1 << (OW - 1)) - 64'd1);
    localparam logic signed [SW-1:0] S_MIN = -SW'(64'd1 << (OW - 1));
    localparam logic signed [SW-1:0] ONE   = SW'(64'd1 << WEIGHT_FRAC_BITS);

    logic [LW-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= bw_pkg::LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    assign busy = 1'b0;

    // valid chain through the front stages
    logic [6:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:1], start};
    end

    // stage 1: edge vectors
    logic [CW-1:0] a_in [3];
    logic [CW-1:0] b_in [3];
    logic [CW-1:0] c_in [3];
    logic [CW-1:0] p_in [3];
    logic signed [EW-1:0] e0_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];

    always_comb
    begin
        a_in[0] = ax; a_in[1] = ay; a_in[2] = az;
        b_in[0] = bx; b_in[1] = by; b_in[2] = bz;
        c_in[0] = cx; c_in[1] = cy; c_in[2] = cz;
        p_in[0] = px; p_in[1] = py; p_in[2] = pz;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e0_reg[i] <= $signed({b_in[i][CW-1], b_in[i]}) - $signed({a_in[i][CW-1], a_in[i]});
            e1_reg[i] <= $signed({c_in[i][CW-1], c_in[i]}) - $signed({a_in[i][CW-1], a_in[i]});
            e2_reg[i] <= $signed({p_in[i][CW-1], p_in[i]}) - $signed({a_in[i][CW-1], a_in[i]});
        end
    end

    // stage 2: component products
    logic signed [PW-1:0] p00_reg [3];
    logic signed [PW-1:0] p01_reg [3];
    logic signed [PW-1:0] p11_reg [3];
    logic signed [PW-1:0] p20_reg [3];
    logic signed [PW-1:0] p21_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p00_reg[i] <= e0_reg[i] * e0_reg[i];
            p01_reg[i] <= e0_reg[i] * e1_reg[i];
            p11_reg[i] <= e1_reg[i] * e1_reg[i];
            p20_reg[i] <= e2_reg[i] * e0_reg[i];
            p21_reg[i] <= e2_reg[i] * e1_reg[i];
        end
    end

    // stage 3: dot products
    logic signed [DW-1:0] d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;

    always_ff @(posedge clk)
    begin
        d00_reg <= DW'(p00_reg[0]) + DW'(p00_reg[1]) + DW'(p00_reg[2]);
        d01_reg <= DW'(p01_reg[0]) + DW'(p01_reg[1]) + DW'(p01_reg[2]);
        d11_reg <= DW'(p11_reg[0]) + DW'(p11_reg[1]) + DW'(p11_reg[2]);
        d20_reg <= DW'(p20_reg[0]) + DW'(p20_reg[1]) + DW'(p20_reg[2]);
        d21_reg <= DW'(p21_reg[0]) + DW'(p21_reg[1]) + DW'(p21_reg[2]);
    end

    // stage 4: gram products
    logic signed [MW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;

    always_ff @(posedge clk)
    begin
        m0_reg <= d00_reg * d11_reg;
        m1_reg <= d01_reg * d01_reg;
        m2_reg <= d11_reg * d20_reg;
        m3_reg <= d01_reg * d21_reg;
        m4_reg <= d00_reg * d21_reg;
        m5_reg <= d01_reg * d20_reg;
    end

    // stage 5: denominator and numerators
    logic signed [GW-1:0] den_reg, nv_reg, nw_reg;

    always_ff @(posedge clk)
    begin
        den_reg <= GW'(m0_reg) - GW'(m1_reg);
        nv_reg  <= GW'(m2_reg) - GW'(m3_reg);
        nw_reg  <= GW'(m4_reg) - GW'(m5_reg);
    end

    // stage 6: magnitudes and quotient signs
    logic [GW-1:0] dmag_reg, nvmag_reg, nwmag_reg;
    logic          neg_v6_reg, neg_w6_reg;

    always_ff @(posedge clk)
    begin
        dmag_reg   <= den_reg[GW-1] ? GW'(-den_reg) : GW'(den_reg);
        nvmag_reg  <= nv_reg[GW-1]  ? GW'(-nv_reg)  : GW'(nv_reg);
        nwmag_reg  <= nw_reg[GW-1]  ? GW'(-nw_reg)  : GW'(nw_reg);
        neg_v6_reg <= nv_reg[GW-1] ^ den_reg[GW-1];
        neg_w6_reg <= nw_reg[GW-1] ^ den_reg[GW-1];
    end

    // stage 7: degenerate test and quotient overflow test
    logic [XW-1:0] xv_next, xw_next;
    logic [XW-1:0] xv_reg, xw_reg;
    logic [GW-1:0] dmag7_reg;
    bw_pkg::bw_side_t side7_reg;
    logic          small_den;

    always_comb
    begin
        xv_next   = {nvmag_reg, {WEIGHT_FRAC_BITS{1'b0}}};
        xw_next   = {nwmag_reg, {WEIGHT_FRAC_BITS{1'b0}}};
        small_den = (dmag_reg[GW-1:LW] == '0) && (dmag_reg[LW-1:0] < limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side7_reg <= '0;
        else
        begin
            side7_reg.valid <= vld_reg[6];
            side7_reg.degen <= small_den || (dmag_reg == '0);
            side7_reg.neg_v <= neg_v6_reg;
            side7_reg.neg_w <= neg_w6_reg;
            side7_reg.ovf_v <= GW'(xv_next[XW-1:QB]) >= dmag_reg;
            side7_reg.ovf_w <= GW'(xw_next[XW-1:QB]) >= dmag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xv_reg    <= xv_next;
        xw_reg    <= xw_next;
        dmag7_reg <= dmag_reg;
    end

    // dividers, one quotient bit per stage
    logic [QB-1:0] qv, qw;

    bw_divider #(.GW(GW), .XW(XW), .QB(QB)) u_div_v (
        .clk      (clk),
        .dividend (xv_reg),
        .divisor  (dmag7_reg),
        .quotient (qv)
    );

    bw_divider #(.GW(GW), .XW(XW), .QB(QB)) u_div_w (
        .clk      (clk),
        .dividend (xw_reg),
        .divisor  (dmag7_reg),
        .quotient (qw)
    );

    bw_pkg::bw_side_t side_reg [QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QB; k++)
                side_reg[k] <= '0;
        end
        else
        begin
            side_reg[0] <= side7_reg;
            for (int k = 1; k < QB; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // clamp v and w
    bw_pkg::bw_side_t side_q;
    logic                  sat_v, sat_w;
    logic signed [OW-1:0]  v_next, w_next;

    always_comb
    begin
        side_q = side_reg[QB-1];
        sat_v  = side_q.ovf_v || (side_q.neg_v ? (qv > MAX_NEG) : (qv > MAX_POS));
        sat_w  = side_q.ovf_w || (side_q.neg_w ? (qw > MAX_NEG) : (qw > MAX_POS));
        if (sat_v)
            v_next = side_q.neg_v ? W_MIN : W_MAX;
        else
            v_next = side_q.neg_v ? OW'(-qv) : OW'(qv);
        if (sat_w)
            w_next = side_q.neg_w ? W_MIN : W_MAX;
        else
            w_next = side_q.neg_w ? OW'(-qw) : OW'(qw);
    end

    logic signed [OW-1:0] v_reg, w_reg;
    logic                 sat_reg, degen_reg, fv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= side_q.valid;
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= side_q.degen ? '0 : v_next;
        w_reg     <= side_q.degen ? '0 : w_next;
        sat_reg   <= !side_q.degen && (sat_v || sat_w);
        degen_reg <= side_q.degen;
    end

    // u = one - v - w, then clamp
    logic signed [SW-1:0] u_sum;
    logic signed [OW-1:0] u_next;
    logic                 sat_u;

    always_comb
    begin
        u_sum = ONE - SW'(v_reg) - SW'(w_reg);
        sat_u = 1'b0;
        if (u_sum > S_MAX)
        begin
            u_next = W_MAX;
            sat_u  = 1'b1;
        end
        else if (u_sum < S_MIN)
        begin
            u_next = W_MIN;
            sat_u  = 1'b1;
        end
        else
        begin
            u_next = OW'(u_sum);
        end
    end

    logic done_reg;
    logic [OW-1:0] u_out_reg, v_out_reg, w_out_reg;
    logic          degen_out_reg, sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fv_reg;
    end

    always_ff @(posedge clk)
    begin
        u_out_reg     <= u_next;
        v_out_reg     <= v_reg;
        w_out_reg     <= w_reg;
        degen_out_reg <= degen_reg;
        sat_out_reg   <= sat_reg || (!degen_reg && sat_u);
    end

    assign done       = done_reg;
    assign weight_u   = u_out_reg;
    assign weight_v   = v_out_reg;
    assign weight_w   = w_out_reg;
    assign degenerate = degen_out_reg;
    assign saturated  = sat_out_reg;

endmodule

// File: tb/barycentric_weights_core_tb.sv
`timescale 1ns / 1ps

module barycentric_weights_core_tb;

    localparam int CW        = bw_pkg::COORD_WIDTH;
    localparam int WW        = bw_pkg::WEIGHT_WIDTH;
    localparam int LW        = bw_pkg::LIMIT_WIDTH;
    localparam int DRAIN     = 9 + bw_pkg::QUOT_BITS + 8;
    localparam int STALL_MAX = 2000;
    localparam logic [WW-1:0] W_ONE = WW'(1) << bw_pkg::WEIGHT_FRAC_BITS;
    localparam logic [WW-1:0] W_MAX = 32'h7fff_ffff;
    localparam logic [WW-1:0] W_MIN = 32'h8000_0000;

    // coordinate order: ax ay az bx by bz cx cy cz px py pz
    typedef logic [11:0][CW-1:0] coords_t;

    typedef struct packed {
        logic [WW-1:0] u;
        logic [WW-1:0] v;
        logic [WW-1:0] w;
        logic          degen;
        logic          sat;
    } weights_t;

    typedef struct {
        coords_t  pts;
        bit       typed;
        weights_t want;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    coords_t                item;
    logic                   cfg_wr_en;
    logic [LW-1:0]          cfg_wr_data;
    logic                   done;
    logic [WW-1:0]          weight_u;
    logic [WW-1:0]          weight_v;
    logic [WW-1:0]          weight_w;
    logic                   degenerate;
    logic                   saturated;

    logic [LW-1:0]          limit_copy;
    weights_t               pending_weights[$];
    row_t                   directed_rows[$];
    int                     errors;
    int                     stall_cycles;
    bit                     idle_on;

    barycentric_weights_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .ax         (item[0]),
        .ay         (item[1]),
        .az         (item[2]),
        .bx         (item[3]),
        .by         (item[4]),
        .bz         (item[5]),
        .cx         (item[6]),
        .cy         (item[7]),
        .cz         (item[8]),
        .px         (item[9]),
        .py         (item[10]),
        .pz         (item[11]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .weight_u   (weight_u),
        .weight_v   (weight_v),
        .weight_w   (weight_w),
        .degenerate (degenerate),
        .saturated  (saturated)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [127:0] clamp_weight(input logic signed [127:0] x,
                                                         inout bit sat);
        if (x > 128'sh7fff_ffff)
        begin
            sat = 1'b1;
            return 128'sh7fff_ffff;
        end
        if (x < -128'sh8000_0000)
        begin
            sat = 1'b1;
            return -128'sh8000_0000;
        end
        return x;
    endfunction

    function automatic weights_t solve_weights(input coords_t p, input logic [31:0] lim);
        longint                 e0[3], e1[3], e2[3];
        longint                 d00, d01, d11, d20, d21;
        logic signed [127:0]    x00, x01, x11, x20, x21, den, mag, nv, nw, qv, qw, qu;
        bit                     sat;
        weights_t               r;
        d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
        for (int i = 0; i < 3; i++)
        begin
            e0[i] = longint'($signed(p[3 + i])) - longint'($signed(p[i]));
            e1[i] = longint'($signed(p[6 + i])) - longint'($signed(p[i]));
            e2[i] = longint'($signed(p[9 + i])) - longint'($signed(p[i]));
            d00 += e0[i] * e0[i];
            d01 += e0[i] * e1[i];
            d11 += e1[i] * e1[i];
            d20 += e2[i] * e0[i];
            d21 += e2[i] * e1[i];
        end
        x00 = d00; x01 = d01; x11 = d11; x20 = d20; x21 = d21;
        den = x00 * x11 - x01 * x01;
        mag = (den < 0) ? -den : den;
        sat = 1'b0;
        r.degen = (den == 0) || (mag < {96'b0, lim});
        if (r.degen)
        begin
            r.u = W_ONE;
            r.v = '0;
            r.w = '0;
        end
        else
        begin
            nv = x11 * x20 - x01 * x21;
            nw = x00 * x21 - x01 * x20;
            // signed divide truncates toward zero
            qv = clamp_weight((nv <<< bw_pkg::WEIGHT_FRAC_BITS) / den, sat);
            qw = clamp_weight((nw <<< bw_pkg::WEIGHT_FRAC_BITS) / den, sat);
            qu = clamp_weight((128'sd1 <<< bw_pkg::WEIGHT_FRAC_BITS) - qv - qw, sat);
            r.u = qu[WW-1:0];
            r.v = qv[WW-1:0];
            r.w = qw[WW-1:0];
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic coords_t pack_coords(input int ax, input int ay, input int az,
                                            input int bx, input int by, input int bz,
                                            input int cx, input int cy, input int cz,
                                            input int px, input int py, input int pz);
        coords_t p;
        p[0] = CW'(ax); p[1] = CW'(ay); p[2]  = CW'(az);
        p[3] = CW'(bx); p[4] = CW'(by); p[5]  = CW'(bz);
        p[6] = CW'(cx); p[7] = CW'(cy); p[8]  = CW'(cz);
        p[9] = CW'(px); p[10] = CW'(py); p[11] = CW'(pz);
        return p;
    endfunction

    function automatic coords_t random_triangle();
        coords_t p;
        int      base[3], d[3], k, s, t, jit;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                for (int i = 0; i < 12; i++)
                    p[i] = CW'($urandom);
            end
            3, 4:
            begin
                for (int i = 0; i < 12; i++)
                    p[i] = CW'(int'($urandom_range(0, 16)) - 8);
            end
            5, 6:
            begin
                // nearly collinear corners, small jitter on C
                k = int'($urandom_range(0, 8)) - 4;
                jit = $urandom_range(0, 3);
                for (int i = 0; i < 3; i++)
                begin
                    base[i] = int'($urandom_range(0, 4000)) - 2000;
                    d[i] = int'($urandom_range(0, 400)) - 200;
                    p[i] = CW'(base[i]);
                    p[3 + i] = CW'(base[i] + d[i]);
                    p[6 + i] = CW'(base[i] + k * d[i] + ((i == jit) ? 1 : 0));
                    p[9 + i] = CW'($urandom);
                end
            end
            default:
            begin
                // point spanned by the edges, mostly inside the triangle
                s = $urandom_range(0, 20);
                t = $urandom_range(0, 20 - s);
                for (int i = 0; i < 3; i++)
                begin
                    base[i] = int'($urandom_range(0, 2000)) - 1000;
                    d[i] = int'($urandom_range(0, 2000)) - 1000;
                    k = int'($urandom_range(0, 2000)) - 1000;
                    p[i] = CW'(base[i]);
                    p[3 + i] = CW'(d[i]);
                    p[6 + i] = CW'(k);
                    p[9 + i] = CW'(base[i] + (s * (d[i] - base[i]) + t * (k - base[i])) / 16
                                   + int'($urandom_range(0, 2)) - 1);
                end
            end
        endcase
        return p;
    endfunction

    task automatic check_field(input string name, input logic [WW-1:0] want,
                               input logic [WW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_row(input row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // one input transfer; the expectation is queued at the accepting edge
    task automatic send_item(input coords_t p, input bit typed, input weights_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item  <= p;
        start <= 1'b1;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        pending_weights.insert(pending_weights.size(),
                               typed ? want : solve_weights(p, limit_copy));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        limit_copy = value;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_weights.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual u=%h v=%h w=%h",
                         $time, weight_u, weight_v, weight_w);
                errors++;
            end
            else
            begin
                weights_t want;
                want = pending_weights.pop_front();
                check_field("weight_u", want.u, weight_u);
                check_field("weight_v", want.v, weight_v);
                check_field("weight_w", want.w, weight_w);
                check_field("degenerate", WW'(want.degen), WW'(degenerate));
                check_field("saturated", WW'(want.sat), WW'(saturated));
            end
        end
    end

    always @(negedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [LW-1:0]          phase_limits[5];
        weights_t               none;
        none = '0;
        errors = 0;
        stall_cycles = 0;
        idle_on = 1'b1;
        limit_copy = bw_pkg::LIMIT_RESET;
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row('{pack_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{W_ONE, '0, '0, 1'b1, 1'b0}});
        add_row('{pack_coords(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767, 32767, 32767), 1,
                  '{W_ONE, '0, '0, 1'b1, 1'b0}});
        add_row('{pack_coords(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768, -32768, -32768, -32768),
                  1, '{W_ONE, '0, '0, 1'b1, 1'b0}});
        // unit right triangle, denominator 1 just at the reset limit
        add_row('{pack_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0), 1,
                  '{W_ONE, '0, '0, 1'b0, 1'b0}});
        add_row('{pack_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0), 1,
                  '{'0, W_ONE, '0, 1'b0, 1'b0}});
        add_row('{pack_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0), 1,
                  '{'0, '0, W_ONE, 1'b0, 1'b0}});
        add_row('{pack_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 0, 0), 1,
                  '{32'h8100_0001, W_MAX, '0, 1'b0, 1'b1}});
        add_row('{pack_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 0, 0), 1,
                  '{W_MAX, W_MIN, '0, 1'b0, 1'b1}});
        // collinear corners, zero denominator
        add_row('{pack_coords(0, 0, 0, 1, 1, 1, 2, 2, 2, 5, -3, 7), 1,
                  '{W_ONE, '0, '0, 1'b1, 1'b0}});
        add_row('{pack_coords(-32768, -32768, -32768, 32767, -32768, -32768,
                              -32768, 32767, -32768, 32767, 32767, 32767),
                  0, none});
        add_row('{pack_coords(32767, -32768, 0, -32768, 32767, 0,
                              0, 0, 32767, -32768, -32768, -32768), 0, none});
        add_row('{pack_coords(10, -20, 30, 40, 5, -7, -3, 12, 9, 8, 1, 2),
                  0, none});
        add_row('{pack_coords(0, 0, 0, 3, 0, 0, 0, 7, 0, 1, 1, 0), 0, none});
        add_row('{pack_coords(100, 100, 100, -100, 100, 100, 100, -100, 100,
                              0, 0, 0), 0, none});
        foreach (directed_rows[i])
            send_item(directed_rows[i].pts, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        phase_limits[0] = 32'h0;
        phase_limits[1] = 32'hffff_ffff;
        phase_limits[2] = $urandom;
        phase_limits[3] = 32'h0000_1000;
        phase_limits[4] = 32'h1;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(phase_limits[ph]);
            // odd phases run back to back with no gaps
            idle_on = (ph % 2) == 0;
            if (ph == 0)
                send_item(pack_coords(0, 0, 0, 1, 1, 1, 2, 2, 2, 0, 0, 0), 1,
                          '{W_ONE, '0, '0, 1'b1, 1'b0});
            for (int n = 0; n < 190; n++)
                send_item(random_triangle(), 0, none);
            wait_drained();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
